// File: rtl/core/bfg_pkg.sv
package bfg_pkg;

    localparam int ORDER_MAX      = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int ORDER_W        = 5;
    localparam int COORD_W        = 13;
    localparam int RADIUS_W       = 21;
    localparam int SQ_W           = 2 * RADIUS_W;
    localparam int RATIO_W        = 43;
    localparam int Q_W            = 63;
    localparam int SAT_SHIFT      = 30;
    localparam logic [Q_W-1:0] QCAP = Q_W'(1) << 62;
    localparam logic [Q_W-1:0] QONE = Q_W'(1) << 32;

    localparam int PIX_W    = 32;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 56;
    localparam int ADDR_W   = 5;

    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_BANDPASS = 2'd2,
        MODE_BANDSTOP = 2'd3
    } mode_t;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_CSAMPLE = 3'd1;
    localparam logic [2:0] REG_CLINE   = 3'd2;
    localparam logic [2:0] REG_CUTOFF  = 3'd3;
    localparam logic [2:0] REG_BAND    = 3'd4;
    localparam logic [2:0] REG_ORDER   = 3'd5;

    // item sideband that rides along every stage
    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic signed [PIX_W-1:0] pixel;
    } tag_t;

endpackage

// File: rtl/core/bfg_ratio_div.sv
module bfg_ratio_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [bfg_pkg::RATIO_W-1:0] num,
    input  logic [bfg_pkg::RATIO_W-1:0] den,
    input  bfg_pkg::tag_t               tag_in,
    output logic [bfg_pkg::Q_W-1:0]     q,
    output bfg_pkg::tag_t               tag_out
);
    import bfg_pkg::*;

    localparam int STEPS = Q_W;

    logic [RATIO_W-1:0]   rem_reg [0:STEPS];
    logic [RATIO_W-1:0]   den_reg [0:STEPS];
    logic [SAT_SHIFT-1:0] nb_reg  [0:STEPS];
    logic [Q_W-1:0]       quo_reg [0:STEPS];
    logic                 sat_reg [0:STEPS];
    tag_t                 tag_reg [0:STEPS];

    logic [RATIO_W-1:0]   rem_next [1:STEPS];
    logic [Q_W-1:0]       quo_next [1:STEPS];
    logic [RATIO_W:0]     cand     [1:STEPS];

    logic [Q_W:0]         round_sum;
    logic [Q_W-1:0]       q_reg;
    tag_t                 tag_out_reg;

    // one quotient bit per stage, restoring
    always_comb
    begin
        for (int j = 1; j <= STEPS; j++)
        begin
            cand[j] = {rem_reg[j-1], nb_reg[j-1][SAT_SHIFT-1]};
            if (cand[j] >= {1'b0, den_reg[j-1]})
            begin
                rem_next[j] = RATIO_W'(cand[j] - {1'b0, den_reg[j-1]});
                quo_next[j] = {quo_reg[j-1][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = RATIO_W'(cand[j]);
                quo_next[j] = {quo_reg[j-1][Q_W-2:0], 1'b0};
            end
        end
    end

    assign round_sum = {1'b0, quo_reg[STEPS]} + (Q_W+1)'(1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient would reach 2^30 or more: saturate
            sat_reg[0] <= ({{SAT_SHIFT{1'b0}}, num} >= {den, {SAT_SHIFT{1'b0}}});
            rem_reg[0] <= RATIO_W'(num >> SAT_SHIFT);
            nb_reg[0]  <= num[SAT_SHIFT-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            for (int j = 1; j <= STEPS; j++)
            begin
                sat_reg[j] <= sat_reg[j-1];
                rem_reg[j] <= rem_next[j];
                nb_reg[j]  <= {nb_reg[j-1][SAT_SHIFT-2:0], 1'b0};
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= quo_next[j];
            end
            if (sat_reg[STEPS] || (round_sum[Q_W:1] > QCAP))
                q_reg <= QCAP;
            else
                q_reg <= round_sum[Q_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= STEPS; j++)
                tag_reg[j] <= '0;
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int j = 1; j <= STEPS; j++)
                tag_reg[j] <= tag_reg[j-1];
            tag_out_reg <= tag_reg[STEPS];
        end
    end

    assign q       = q_reg;
    assign tag_out = tag_out_reg;

endmodule

// File: rtl/core/bfg_qmul.sv
module bfg_qmul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [bfg_pkg::Q_W-1:0] a,
    input  logic [bfg_pkg::Q_W-1:0] b,
    input  logic                    apply,
    input  bfg_pkg::tag_t           tag_in,
    output logic [bfg_pkg::Q_W-1:0] p,
    output logic [bfg_pkg::Q_W-1:0] b_out,
    output bfg_pkg::tag_t           tag_out
);
    import bfg_pkg::*;

    localparam int HI_W  = Q_W - 32;
    localparam int SUM_W = Q_W + 2;

    logic [2*HI_W-1:0]    hh_reg;
    logic [HI_W+31:0]     ahbl_reg;
    logic [HI_W+31:0]     albh_reg;
    logic [63:0]          albl_reg;
    logic [Q_W-1:0]       a_reg;
    logic [Q_W-1:0]       b_reg;
    logic                 apply_reg;
    tag_t                 tag_reg;

    logic [SUM_W-1:0]     lo_round;
    logic [SUM_W-1:0]     sum;
    logic                 hh_sat;

    logic [Q_W-1:0]       p_reg;
    logic [Q_W-1:0]       b_out_reg;
    tag_t                 tag_out_reg;

    assign lo_round = (SUM_W'(albl_reg) + (SUM_W'(1) << 31)) >> 32;
    assign sum      = (SUM_W'(hh_reg) << 32) + SUM_W'(ahbl_reg) + SUM_W'(albh_reg) + lo_round;
    assign hh_sat   = (hh_reg >= ((2*HI_W)'(1) << 30));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg    <= a[Q_W-1:32] * b[Q_W-1:32];
            ahbl_reg  <= a[Q_W-1:32] * b[31:0];
            albh_reg  <= a[31:0] * b[Q_W-1:32];
            albl_reg  <= a[31:0] * b[31:0];
            a_reg     <= a;
            b_reg     <= b;
            apply_reg <= apply;

            if (!apply_reg)
                p_reg <= a_reg;
            else if (hh_sat || (sum > SUM_W'(QCAP)))
                p_reg <= QCAP;
            else
                p_reg <= sum[Q_W-1:0];
            b_out_reg <= b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg     <= '0;
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_reg     <= tag_in;
            tag_out_reg <= tag_reg;
        end
    end

    assign p       = p_reg;
    assign b_out   = b_out_reg;
    assign tag_out = tag_out_reg;

endmodule

// File: rtl/core/bfg_gain_div.sv
module bfg_gain_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [bfg_pkg::Q_W-1:0]    den,
    input  bfg_pkg::tag_t              tag_in,
    output logic [bfg_pkg::GAIN_W-1:0] gain,
    output bfg_pkg::tag_t              tag_out
);
    import bfg_pkg::*;

    localparam int STEPS = GAIN_W;

    logic [Q_W-1:0]    num;
    logic [Q_W-1:0]    rem_reg [0:STEPS];
    logic [Q_W-1:0]    den_reg [0:STEPS];
    logic [STEPS-1:0]  nb_reg  [0:STEPS];
    logic [GAIN_W-1:0] quo_reg [0:STEPS];
    tag_t              tag_reg [0:STEPS];

    logic [Q_W-1:0]    rem_next [1:STEPS];
    logic [GAIN_W-1:0] quo_next [1:STEPS];
    logic [Q_W:0]      cand     [1:STEPS];

    logic [GAIN_W-1:0] gain_reg;
    tag_t              tag_out_reg;

    // 2^(frac+32) plus half the divisor, for round half up
    assign num = (Q_W'(1) << (GAIN_FRAC_BITS + 32)) + (den >> 1);

    always_comb
    begin
        for (int j = 1; j <= STEPS; j++)
        begin
            cand[j] = {rem_reg[j-1], nb_reg[j-1][STEPS-1]};
            if (cand[j] >= {1'b0, den_reg[j-1]})
            begin
                rem_next[j] = Q_W'(cand[j] - {1'b0, den_reg[j-1]});
                quo_next[j] = {quo_reg[j-1][GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = Q_W'(cand[j]);
                quo_next[j] = {quo_reg[j-1][GAIN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num >> STEPS;
            nb_reg[0]  <= num[STEPS-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            for (int j = 1; j <= STEPS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                nb_reg[j]  <= {nb_reg[j-1][STEPS-2:0], 1'b0};
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= quo_next[j];
            end
            gain_reg <= quo_reg[STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= STEPS; j++)
                tag_reg[j] <= '0;
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int j = 1; j <= STEPS; j++)
                tag_reg[j] <= tag_reg[j-1];
            tag_out_reg <= tag_reg[STEPS];
        end
    end

    assign gain    = gain_reg;
    assign tag_out = tag_out_reg;

endmodule

// File: rtl/core/butterworth_frequency_gain_core.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Depth is set by the 63-step ratio divider, the 16 Q32 multiplier stages
// and the 17-step gain divider.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
module butterworth_frequency_gain_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // sample_index [12:0], line_index [25:13], pixel_value [57:26]
    input  logic [bfg_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // filtered_value [31:0], applied_gain [48:32]
    output logic [bfg_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bfg_pkg::*;

    localparam int CHAIN = ORDER_MAX - 1;
    localparam int D_W   = COORD_W + 1;
    localparam int SQ1_W = 2 * COORD_W;

    // configuration
    mode_t               filter_mode_reg;
    logic [COORD_W-1:0]  center_sample_reg;
    logic [COORD_W-1:0]  center_line_reg;
    logic [RADIUS_W-1:0] cutoff_radius_reg;
    logic [RADIUS_W-1:0] band_width_reg;
    logic [ORDER_W-1:0]  filter_order_reg;
    logic                cfg_write;
    logic [2:0]          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg   <= MODE_LOWPASS;
            center_sample_reg <= COORD_W'(2048);
            center_line_reg   <= COORD_W'(2048);
            cutoff_radius_reg <= RADIUS_W'(25600);
            band_width_reg    <= RADIUS_W'(2560);
            filter_order_reg  <= ORDER_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:    filter_mode_reg   <= mode_t'(pwdata[1:0]);
                REG_CSAMPLE: center_sample_reg <= pwdata[COORD_W-1:0];
                REG_CLINE:   center_line_reg   <= pwdata[COORD_W-1:0];
                REG_CUTOFF:  cutoff_radius_reg <= pwdata[RADIUS_W-1:0];
                REG_BAND:    band_width_reg    <= pwdata[RADIUS_W-1:0];
                REG_ORDER:   filter_order_reg  <= pwdata[ORDER_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_MODE:    prdata = 32'(filter_mode_reg);
            REG_CSAMPLE: prdata = 32'(center_sample_reg);
            REG_CLINE:   prdata = 32'(center_line_reg);
            REG_CUTOFF:  prdata = 32'(cutoff_radius_reg);
            REG_BAND:    prdata = 32'(band_width_reg);
            REG_ORDER:   prdata = 32'(filter_order_reg);
            default:     prdata = '0;
        endcase
    end

    // pipeline advance
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // front end: distance
    logic signed [D_W-1:0] dx_reg, dy_reg;
    tag_t                  f1_tag_reg;
    logic [SQ1_W-1:0]      sqx_reg, sqy_reg;
    logic [SQ_W-1:0]       c2_f2_reg, w2_f2_reg;
    tag_t                  f2_tag_reg;
    logic [RATIO_W-1:0]    s_reg;
    logic [SQ_W-1:0]       c2_reg, w2_reg;
    tag_t                  f3_tag_reg;
    logic signed [2*D_W-1:0] sqx_full, sqy_full;

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= $signed({1'b0, s_tdata[COORD_W-1:0]}) -
                         $signed({1'b0, center_sample_reg});
            dy_reg    <= $signed({1'b0, s_tdata[2*COORD_W-1:COORD_W]}) -
                         $signed({1'b0, center_line_reg});
            sqx_reg   <= sqx_full[SQ1_W-1:0];
            sqy_reg   <= sqy_full[SQ1_W-1:0];
            c2_f2_reg <= cutoff_radius_reg * cutoff_radius_reg;
            w2_f2_reg <= band_width_reg * band_width_reg;
            s_reg     <= RATIO_W'({(SQ1_W+1)'(sqx_reg) + (SQ1_W+1)'(sqy_reg), 16'b0});
            c2_reg    <= c2_f2_reg;
            w2_reg    <= w2_f2_reg;
        end
    end

    // ratio operand select
    logic [RATIO_W-1:0] c2_ext, w2_ext, e_val;
    logic [RATIO_W-1:0] num_a, den_a;
    tag_t               div_tag;

    assign c2_ext = RATIO_W'(c2_reg);
    assign w2_ext = RATIO_W'(w2_reg);
    assign e_val  = (s_reg >= c2_ext) ? (s_reg - c2_ext) : (c2_ext - s_reg);

    always_comb
    begin
        div_tag = f3_tag_reg;
        case (filter_mode_reg)
            MODE_LOWPASS:
            begin
                num_a        = s_reg;
                den_a        = c2_ext;
                div_tag.zero = (c2_reg == '0);
            end
            MODE_HIGHPASS:
            begin
                num_a        = c2_ext;
                den_a        = s_reg;
                div_tag.zero = (s_reg == '0);
            end
            default:
            begin
                num_a        = w2_ext;
                den_a        = e_val;
                div_tag.zero = (e_val == '0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_tag_reg <= '0;
            f2_tag_reg <= '0;
            f3_tag_reg <= '0;
        end
        else if (en)
        begin
            f1_tag_reg.valid <= s_tvalid;
            f1_tag_reg.zero  <= 1'b0;
            f1_tag_reg.pixel <= $signed(s_tdata[2*COORD_W+PIX_W-1:2*COORD_W]);
            f2_tag_reg       <= f1_tag_reg;
            f3_tag_reg       <= f2_tag_reg;
        end
    end

    // ratios
    logic [Q_W-1:0] qa, qb;
    tag_t           qa_tag;

    bfg_ratio_div u_div_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (num_a),
        .den     (den_a),
        .tag_in  (div_tag),
        .q       (qa),
        .tag_out (qa_tag)
    );

    bfg_ratio_div u_div_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (s_reg),
        .den     (e_val),
        .tag_in  (div_tag),
        .q       (qb),
        .tag_out ()
    );

    // band product, then power chain
    logic [Q_W-1:0]     p_chain [0:CHAIN];
    logic [Q_W-1:0]     q_chain [0:CHAIN];
    tag_t               t_chain [0:CHAIN];
    logic [ORDER_W-1:0] n_eff;

    assign n_eff = (filter_order_reg > ORDER_W'(ORDER_MAX)) ? ORDER_W'(ORDER_MAX)
                                                            : filter_order_reg;

    bfg_qmul u_band_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .a       (qa),
        .b       (qb),
        .apply   (filter_mode_reg[1]),
        .tag_in  (qa_tag),
        .p       (p_chain[0]),
        .b_out   (),
        .tag_out (t_chain[0])
    );

    assign q_chain[0] = p_chain[0];

    for (genvar k = 1; k <= CHAIN; k++)
    begin : g_pow
        bfg_qmul u_pow_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .a       (p_chain[k-1]),
            .b       (q_chain[k-1]),
            .apply   (ORDER_W'(k) < n_eff),
            .tag_in  (t_chain[k-1]),
            .p       (p_chain[k]),
            .b_out   (q_chain[k]),
            .tag_out (t_chain[k])
        );
    end

    // gain
    logic [Q_W-1:0]    gden;
    logic [GAIN_W-1:0] gdiv;
    tag_t              g_tag;
    logic [GAIN_W-1:0] g0;
    logic [GAIN_W-1:0] gsel;

    assign gden = (filter_order_reg == '0) ? (QONE << 1) : (QONE + p_chain[CHAIN]);

    bfg_gain_div u_gain_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .den     (gden),
        .tag_in  (t_chain[CHAIN]),
        .gain    (gdiv),
        .tag_out (g_tag)
    );

    assign g0   = g_tag.zero ? '0 : gdiv;
    assign gsel = (filter_mode_reg == MODE_BANDPASS) ? (GAIN_W'(1) << GAIN_FRAC_BITS) - g0
                                                     : g0;

    // apply gain
    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int M_W    = PROD_W - GAIN_FRAC_BITS + 1;

    logic [GAIN_W-1:0]     g1_gain_reg;
    logic signed [PIX_W-1:0] g1_pix_reg;
    logic                  g1_valid_reg;
    logic [PROD_W-1:0]     g2_prod_reg;
    logic                  g2_neg_reg;
    logic [GAIN_W-1:0]     g2_gain_reg;
    logic                  g2_valid_reg;
    logic [PIX_W-1:0]      mag;
    logic [M_W-1:0]        m_val;
    logic [PIX_W-1:0]      res;
    logic [PIX_W-1:0]      out_value_reg;
    logic [GAIN_W-1:0]     out_gain_reg;

    assign mag   = g1_pix_reg[PIX_W-1] ? (~g1_pix_reg + 1'b1) : g1_pix_reg;
    assign m_val = M_W'((PROD_W+1)'(g2_prod_reg) +
                        ((PROD_W+1)'(1) << (GAIN_FRAC_BITS - 1)) >> GAIN_FRAC_BITS);

    always_comb
    begin
        if (g2_neg_reg)
        begin
            if (m_val > M_W'(32'h8000_0000))
                res = 32'h8000_0000;
            else
                res = PIX_W'(-m_val);
        end
        else
        begin
            if (m_val > M_W'(32'h7FFF_FFFF))
                res = 32'h7FFF_FFFF;
            else
                res = m_val[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_gain_reg   <= gsel;
            g1_pix_reg    <= g_tag.pixel;
            g2_prod_reg   <= mag * g1_gain_reg;
            g2_neg_reg    <= g1_pix_reg[PIX_W-1];
            g2_gain_reg   <= g1_gain_reg;
            out_value_reg <= res;
            out_gain_reg  <= g2_gain_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg  <= 1'b0;
            g2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g1_valid_reg  <= g_tag.valid;
            g2_valid_reg  <= g1_valid_reg;
            out_valid_reg <= g2_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - PIX_W - GAIN_W){1'b0}}, out_gain_reg, out_value_reg};

`ifndef SYNTH
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_gain_reg <= (GAIN_W'(1) << GAIN_FRAC_BITS)))
        else $error("applied gain above one");

    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_gain_reg == '0)) |-> (out_value_reg == '0))
        else $error("nonzero output with zero gain");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (g2_valid_reg && !en) |=> g2_valid_reg)
        else $error("item lost inside pipeline during stall");
`endif

endmodule

// File: tb/butterworth_frequency_gain_core_test.sv
`timescale 1ns / 100ps

module butterworth_frequency_gain_core_test;
    import bfg_pkg::*;

    localparam int LATENCY    = 122;
    localparam int WATCHDOG   = 20000;
    localparam int RAND_ITEMS = 800;

    // predicted output of the gain core
    typedef struct {
        logic [31:0] filtered;
        logic [16:0] gain;
    } pixel_result_t;

    // ---------------------------------------------------------------
    // predictor and expected-result queue
    // ---------------------------------------------------------------
    class gain_scoreboard;
        pixel_result_t pending[$];
        logic [1:0]    mode;
        logic [12:0]   csample;
        logic [12:0]   cline;
        logic [20:0]   cutoff;
        logic [20:0]   band;
        logic [4:0]    order;
        int            errors;
        int            checked;

        function new();
            mode    = MODE_LOWPASS;
            csample = 13'd2048;
            cline   = 13'd2048;
            cutoff  = 21'd25600;
            band    = 21'd2560;
            order   = 5'd1;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_MODE:    mode    = val[1:0];
                REG_CSAMPLE: csample = val[12:0];
                REG_CLINE:   cline   = val[12:0];
                REG_CUTOFF:  cutoff  = val[20:0];
                REG_BAND:    band    = val[20:0];
                REG_ORDER:   order   = val[4:0];
                default:     ;
            endcase
        endfunction

        // num * 2^32 / den, round half up, saturate at 2^62
        function logic [63:0] ratio_div(logic [63:0] num, logic [63:0] den);
            logic [127:0] r;
            if (den == 0)
                return 64'd1 << 62;
            if (num / den >= 64'd1 << 30)
                return 64'd1 << 62;
            r = (({64'd0, num} << 33) / den + 1) >> 1;
            return (r > (128'd1 << 62)) ? 64'd1 << 62 : r[63:0];
        endfunction

        // a * b / 2^32, round half up, saturate at 2^62
        function logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] r;
            r = ({64'd0, a} * b + (128'd1 << 31)) >> 32;
            return (r > (128'd1 << 62)) ? 64'd1 << 62 : r[63:0];
        endfunction

        function logic [63:0] gain_of(logic [63:0] q, logic [4:0] n);
            logic [63:0]  p;
            logic [127:0] den;
            int           lim;
            p   = 64'd1 << 32;
            lim = (n > ORDER_MAX) ? ORDER_MAX : n;
            if (lim > 0)
            begin
                p = q;
                for (int k = 1; k < lim; k++)
                    p = q32_mul(p, q);
            end
            den = (128'd1 << 32) + p;
            return (((128'd1 << 48) + den / 2) / den);
        endfunction

        function void note_pixel(logic [12:0] sidx, logic [12:0] lidx, logic [31:0] pix);
            logic signed [63:0] dx, dy;
            logic [63:0]        s, c2, w2, g, e, mag, m;
            pixel_result_t      r;
            dx = $signed({3'd0, sidx}) - $signed({3'd0, csample});
            dy = $signed({3'd0, lidx}) - $signed({3'd0, cline});
            s  = 64'(dx * dx + dy * dy) << 16;
            c2 = 64'(cutoff) * cutoff;
            w2 = 64'(band) * band;
            case (mode)
                MODE_LOWPASS:  g = (c2 == 0) ? 0 : gain_of(ratio_div(s, c2), order);
                MODE_HIGHPASS: g = (s == 0) ? 0 : gain_of(ratio_div(c2, s), order);
                default:
                begin
                    e = (s >= c2) ? s - c2 : c2 - s;
                    g = (e == 0) ? 0 :
                        gain_of(q32_mul(ratio_div(w2, e), ratio_div(s, e)), order);
                    if (mode == MODE_BANDPASS)
                        g = 64'd65536 - g;
                end
            endcase
            mag = pix[31] ? (64'd1 << 32) - pix : {32'd0, pix};
            m   = (mag * g + 64'd32768) >> 16;
            if (pix[31])
            begin
                if (m > 64'h8000_0000)
                    m = 64'h8000_0000;
                r.filtered = 32'(-m);
            end
            else
            begin
                if (m > 64'h7FFF_FFFF)
                    m = 64'h7FFF_FFFF;
                r.filtered = m[31:0];
            end
            r.gain = g[16:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] filt, logic [16:0] gn);
            pixel_result_t x;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result filtered=%h gain=%h", $time, filt, gn);
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (x.filtered !== filt)
            begin
                $display("%0t: filtered_value expected %h actual %h", $time, x.filtered, filt);
                errors++;
            end
            if (x.gain !== gn)
            begin
                $display("%0t: applied_gain expected %h actual %h", $time, x.gain, gn);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    gain_scoreboard sb;
    int  idle_pct;
    bit  hold_sink;
    int  quiet_cycles;

    butterworth_frequency_gain_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // sink side with random stalls and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !hold_sink && ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[48:32]);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("butterworth_frequency_gain_core: mismatch");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_pixel(logic [12:0] sidx, logic [12:0] lidx, logic [31:0] pix);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {6'd0, pix, lidx, sidx};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(sidx, lidx, pix);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(200000)) - 32'd100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [12:0] rand_coord(logic [12:0] c);
        if ($urandom_range(3) == 0)
            return 13'($urandom);
        return 13'(c + $urandom_range(400) - 200);
    endfunction

    task automatic random_phase(int count);
        logic [12:0] sx, ly;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                sx = sb.csample;
                ly = sb.cline;
            end
            else
            begin
                sx = rand_coord(sb.csample);
                ly = rand_coord(sb.cline);
            end
            send_pixel(sx, ly, rand_pixel());
        end
    endtask

    initial
    begin
        logic [31:0] cut;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_pct  = 21;
        hold_sink = 1'b0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, field extremes, center and cutoff radius
        send_pixel(13'd2048, 13'd2048, 32'h0001_0000);
        send_pixel(13'd2148, 13'd2048, 32'h7FFF_FFFF);
        send_pixel(13'd0, 13'd0, 32'h8000_0000);
        send_pixel(13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF);
        send_pixel(13'd4096, 13'd1, 32'h0000_0001);
        drain();

        for (int md = 0; md < 4; md++)
        begin
            reg_write(REG_MODE, md);
            reg_write(REG_CUTOFF, 32'd25600);
            reg_write(REG_ORDER, 32'd2);
            send_pixel(13'd2048, 13'd2048, 32'h0010_0000);   // D = 0
            send_pixel(13'd2148, 13'd2048, 32'h8000_0000);   // D = D0
            send_pixel(13'd2048, 13'd2000, 32'h7FFF_FFFF);
            send_pixel(13'd10, 13'd4000, 32'hFFF0_0000);
            drain();
            reg_write(REG_ORDER, 32'd0);                     // q^0 = 1
            send_pixel(13'd2100, 13'd2100, 32'h0001_0000);
            drain();
            reg_write(REG_ORDER, 32'd31);                    // clamped order
            reg_write(REG_CUTOFF, 32'd0);                    // zero cutoff
            send_pixel(13'd2048, 13'd2048, 32'h0001_0000);
            send_pixel(13'd3000, 13'd100, 32'h0001_0000);
            drain();
        end

        // random settings, extremes included
        for (int ph = 0; ph < 10; ph++)
        begin
            reg_write(REG_MODE, $urandom_range(3));
            reg_write(REG_CSAMPLE, (ph == 0) ? 32'd0 : (ph == 1) ? 32'h1FFF
                                   : $urandom_range(8191));
            reg_write(REG_CLINE, (ph == 1) ? 32'd0 : (ph == 2) ? 32'h1FFF
                                 : $urandom_range(8191));
            cut = (ph == 3) ? 32'h1F_FFFF : (ph == 4) ? 32'd1 : $urandom_range(100000);
            reg_write(REG_CUTOFF, $urandom & 32'hFFE0_0000 | cut);
            reg_write(REG_BAND, (ph == 5) ? 32'h1F_FFFF : (ph == 6) ? 32'd0
                                : $urandom_range(60000));
            reg_write(REG_ORDER, (ph == 7) ? 32'd16 : (ph == 8) ? 32'h1F
                                 : $urandom_range(16));
            reg_write(3'd7, $urandom);                        // unused index
            idle_pct = (ph == 5) ? 0 : 21;
            if (ph == 3)
            begin
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_sink = 1'b0;
                    end
                    random_phase(300);
                join
            end
            else
                random_phase(RAND_ITEMS / 10 - 20);
            drain();
        end

        $display("covered all four modes, zero and clamped orders, D=0 and D=D0,");
        $display("zero cutoff, %0d results checked", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("butterworth_frequency_gain_core: match");
        else
            $display("butterworth_frequency_gain_core: mismatch");
        $finish;
    end
endmodule
